@@ rtl/kbi_pkg.sv @@
// ----------------------------------------------------------------------------
// kbi_pkg - shared types and constants of the keyframe Bezier interpolator
// Key record, queue entry, divider request and back-end state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package kbi_pkg;

  localparam int S_BITS   = 28;     // fraction bits of the curve parameter s
  localparam int PT_W     = 38;     // signed width of curve points and lerps
  localparam int MUL_W    = PT_W + S_BITS + 1;
  localparam int X_W      = 47;     // influence * width + half, fits 47 bits
  localparam int QUO_W    = 34;     // divider quotient width
  localparam int PCT_ONE  = 25600;  // 100.0 percent in Q8.8
  localparam int PCT_HALF = 12800;
  localparam int BEZ_LAST = 8;      // last step of one de Casteljau pass

  // x / 25600 = (x >> 10) / 25. With y = hi * 2^20 + lo and 2^20 = 25 * 41943 + 1,
  // y / 25 = hi * 41943 + (hi + lo) / 25, and (2^30 + 1) / 25 is an exact
  // reciprocal for the folded sum hi + lo.
  localparam int PCT_SH   = 10;
  localparam int FOLD_SH  = 20;
  localparam int FOLD_K   = 41943;
  localparam int RCP_SH   = 30;
  localparam int RCP_M    = 42949673;

  // step k of a pass computes a lerp when bit k is set, else it drops a point
  localparam logic [BEZ_LAST:0] BEZ_COMPUTE = 9'b100110111;

  typedef struct packed {
    logic        [31:0] key_time;
    logic signed [31:0] key_level;
    logic        [14:0] ease_in_pct;
    logic        [14:0] ease_out_pct;
  } key_rec_t;

  typedef struct packed {
    logic        is_query;
    logic [3:0]  key_slot;
    key_rec_t    rec;
    logic [31:0] query_time;
  } qitem_t;

  typedef struct packed {
    logic              start;
    logic [31:0]       rem_init;
    logic [QUO_W-1:0]  dvd_lo;
    logic [4:0]        pairs;
    logic [31:0]       divisor;
  } div_req_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SRCH,
    B_RD_Y0,
    B_RD_Y1,
    B_RD_PREV,
    B_OFF2_MUL,
    B_OFF2_SUM,
    B_OFF1_MUL,
    B_OFF1_SUM,
    B_S_GO,
    B_S_WAIT,
    B_BEZ,
    B_LERP,
    B_FIN
  } back_state_t;

endpackage

`default_nettype wire

@@ rtl/kbi_in_if.sv @@
// ----------------------------------------------------------------------------
// kbi_in_if - request channel of the keyframe Bezier interpolator
// Valid/ready handshake with one load or query request as payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface kbi_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic        [3:0]  key_slot;
  logic        [31:0] key_time;
  logic signed [31:0] key_level;
  logic        [14:0] ease_in_pct;
  logic        [14:0] ease_out_pct;
  logic        [31:0] query_time;

  modport source (
    output valid, mode, key_slot, key_time, key_level, ease_in_pct, ease_out_pct,
           query_time,
    input  ready
  );
  modport sink (
    input  valid, mode, key_slot, key_time, key_level, ease_in_pct, ease_out_pct,
           query_time,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/kbi_out_if.sv @@
// ----------------------------------------------------------------------------
// kbi_out_if - result channel of the keyframe Bezier interpolator
// Valid/ready handshake carrying one curve point per query.
// ----------------------------------------------------------------------------
`default_nettype none

interface kbi_out_if;
  logic               valid;
  logic               ready;
  logic        [31:0] curve_x;
  logic signed [31:0] curve_y;
  logic               in_range;

  modport source (output valid, curve_x, curve_y, in_range, input ready);
  modport sink   (input valid, curve_x, curve_y, in_range, output ready);
endinterface

`default_nettype wire

@@ rtl/kbi_ram.sv @@
// ----------------------------------------------------------------------------
// kbi_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kbi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/kbi_div.sv @@
// ----------------------------------------------------------------------------
// kbi_div - radix-4 restoring divider
// Two quotient bits per cycle; done pulses in the cycle after the last pair.
// ----------------------------------------------------------------------------
`default_nettype none

module kbi_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire kbi_pkg::div_req_t        req,
  output logic                          done,
  output logic [kbi_pkg::QUO_W-1:0]     quo
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [4:0]                  cnt_r, cnt_nxt;
  logic [31:0]                 rem_r, rem_nxt;
  logic [kbi_pkg::QUO_W-1:0]   lo_r, lo_nxt;
  logic [kbi_pkg::QUO_W-1:0]   quo_r, quo_nxt;
  logic [31:0]                 dv_r, dv_nxt;
  logic [32:0]                 trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    quo_nxt  = quo_r;
    dv_nxt   = dv_r;
    trial    = '0;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.pairs;
      rem_nxt  = req.rem_init;
      lo_nxt   = req.dvd_lo;
      quo_nxt  = '0;
      dv_nxt   = req.divisor;
    end else if (busy_r) begin
      for (int j = 0; j < 2; j++) begin
        trial  = {rem_nxt, lo_nxt[kbi_pkg::QUO_W-1]};
        lo_nxt = {lo_nxt[kbi_pkg::QUO_W-2:0], 1'b0};
        if (trial >= {1'b0, dv_r}) begin
          rem_nxt = 32'(trial - {1'b0, dv_r});
          quo_nxt = {quo_nxt[kbi_pkg::QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[31:0];
          quo_nxt = {quo_nxt[kbi_pkg::QUO_W-2:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    quo_r <= quo_nxt;
    dv_r  <= dv_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

@@ rtl/kbi_front.sv @@
// ----------------------------------------------------------------------------
// kbi_front - request intake and two-entry queue
// Classifies each request as load or query and queues it for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module kbi_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  kbi_in_if.sink             in_chan,
  output logic               q_valid,
  output kbi_pkg::qitem_t    q_item,
  input  wire logic          q_ready
);

  kbi_pkg::qitem_t ent_r [2];
  kbi_pkg::qitem_t push_item;
  logic            wr_ptr_r, rd_ptr_r;
  logic [1:0]      cnt_r;
  logic            push, pop;

  assign in_chan.ready = (cnt_r != 2'd2);
  assign push = in_chan.valid && in_chan.ready;
  assign pop  = q_valid && q_ready;

  always_comb begin
    push_item.is_query         = in_chan.mode;
    push_item.key_slot         = in_chan.key_slot;
    push_item.rec.key_time     = in_chan.key_time;
    push_item.rec.key_level    = in_chan.key_level;
    push_item.rec.ease_in_pct  = in_chan.ease_in_pct;
    push_item.rec.ease_out_pct = in_chan.ease_out_pct;
    push_item.query_time       = in_chan.query_time;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = ent_r[rd_ptr_r];

endmodule

`default_nettype wire

@@ rtl/kbi_back.sv @@
// ----------------------------------------------------------------------------
// kbi_back - key table, segment search and Bezier evaluation
// Sequencer around the key RAM, one shared multiplier and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

module kbi_back #(
  parameter int MAX_KEYS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic [4:0]    keys_in_use,
  input  wire logic          q_valid,
  input  wire kbi_pkg::qitem_t q_item,
  output logic               q_ready,
  kbi_out_if.source          out_chan
);

  localparam int AW  = $clog2(MAX_KEYS);
  localparam int CW  = $clog2(MAX_KEYS + 1);
  localparam int PW  = kbi_pkg::PT_W;
  localparam int MW  = kbi_pkg::MUL_W;
  localparam int BW  = kbi_pkg::S_BITS + 1;
  localparam int YW  = kbi_pkg::X_W - kbi_pkg::PCT_SH;  // (x + half) >> 10
  localparam int HW  = YW - kbi_pkg::FOLD_SH;           // folded high part
  localparam int ZW  = kbi_pkg::FOLD_SH + 1;            // hi + lo
  localparam int QLW = ZW - 4;                          // (hi + lo) / 25

  kbi_pkg::back_state_t state_r, state_nxt;

  logic [CW-1:0]        n_r, n_nxt, n_c, idx_inc;
  logic [AW-1:0]        idx_r, idx_nxt, seg_r, seg_nxt, prev_c;
  logic [31:0]          qt_r, qt_nxt, tprev_r, tprev_nxt, t0_r, t0_nxt;
  logic [31:0]          t1_r, t1_nxt, w_r, w_nxt;
  logic signed [31:0]   y0_r, y0_nxt, y1_r, y1_nxt;
  logic [14:0]          ein_r, ein_nxt, eout_r, eout_nxt;
  logic [kbi_pkg::QUO_W-1:0] off1_r, off1_nxt, off2_r, off2_nxt;
  logic [kbi_pkg::QUO_W-1:0] fold_r, fold_nxt;
  logic [kbi_pkg::S_BITS-1:0] s_r, s_nxt;
  logic signed [MW-1:0] mprod_r, mprod_nxt;
  logic signed [PW-1:0] pts_r [4];
  logic signed [PW-1:0] pts_nxt [4];
  logic [3:0]           step_r, step_nxt;
  logic                 ypass_r, ypass_nxt;
  logic signed [PW-1:0] xres_r, xres_nxt;
  logic [31:0]          px_r, px_nxt;
  logic signed [31:0]   py_r, py_nxt;
  logic                 prng_r, prng_nxt;
  logic                 ovld_r, ovld_nxt;
  logic [31:0]          ox_r, ox_nxt;
  logic signed [31:0]   oy_r, oy_nxt;
  logic                 orng_r, orng_nxt;

  // shared multiplier
  logic signed [PW-1:0]             mul_a;
  logic signed [kbi_pkg::S_BITS:0]  mul_b;
  logic signed [MW-1:0]             mul_p;

  logic signed [MW-1:0] lerp_sh;
  logic signed [PW-1:0] lerp_r;
  logic [kbi_pkg::X_W-1:0] xdiv;

  // offset scaling by 1/25600
  logic [YW-1:0]        rcp_y;
  logic [HW-1:0]        rcp_hi;
  logic [ZW-1:0]        rcp_z;
  logic [kbi_pkg::QUO_W-1:0] off_sum;

  // key RAM
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  kbi_pkg::key_rec_t    ram_rd;
  logic [8:0]           slot_ext;
  logic                 wr_ok;

  // divider
  kbi_pkg::div_req_t    dreq;
  logic                 ddone;
  logic [kbi_pkg::QUO_W-1:0] dquo;

  kbi_ram #(.WIDTH($bits(kbi_pkg::key_rec_t)), .DEPTH(MAX_KEYS)) u_keys (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (q_item.rec),
    .raddr (ram_raddr),
    .rdata (ram_rd)
  );

  kbi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .done  (ddone),
    .quo   (dquo)
  );

  assign mul_p = mul_a * mul_b;

  assign lerp_sh = (mprod_r + (MW'(1) <<< (kbi_pkg::S_BITS - 1))) >>> kbi_pkg::S_BITS;
  assign lerp_r  = pts_r[0] + lerp_sh[PW-1:0];
  assign xdiv    = mprod_r[kbi_pkg::X_W-1:0] + kbi_pkg::X_W'(kbi_pkg::PCT_HALF);

  assign rcp_y   = xdiv[kbi_pkg::X_W-1:kbi_pkg::PCT_SH];
  assign rcp_hi  = rcp_y[YW-1:kbi_pkg::FOLD_SH];
  assign rcp_z   = ZW'(rcp_hi) + ZW'(rcp_y[kbi_pkg::FOLD_SH-1:0]);
  assign off_sum = fold_r
                 + kbi_pkg::QUO_W'(mprod_r[kbi_pkg::RCP_SH+QLW-1:kbi_pkg::RCP_SH]);

  assign slot_ext  = {5'd0, q_item.key_slot};
  assign wr_ok     = (32'(q_item.key_slot) < MAX_KEYS);
  assign ram_waddr = slot_ext[AW-1:0];

  assign n_c     = ({27'd0, keys_in_use} > 32'(MAX_KEYS)) ? CW'(MAX_KEYS)
                                                          : CW'(keys_in_use);
  assign idx_inc = CW'(idx_r) + CW'(1);
  assign prev_c  = (seg_r == '0) ? AW'(n_r - CW'(1)) : seg_r - AW'(1);

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    idx_nxt   = idx_r;
    seg_nxt   = seg_r;
    qt_nxt    = qt_r;
    tprev_nxt = tprev_r;
    t0_nxt    = t0_r;
    t1_nxt    = t1_r;
    w_nxt     = w_r;
    y0_nxt    = y0_r;
    y1_nxt    = y1_r;
    ein_nxt   = ein_r;
    eout_nxt  = eout_r;
    off1_nxt  = off1_r;
    off2_nxt  = off2_r;
    fold_nxt  = fold_r;
    s_nxt     = s_r;
    mprod_nxt = mprod_r;
    for (int k = 0; k < 4; k++) pts_nxt[k] = pts_r[k];
    step_nxt  = step_r;
    ypass_nxt = ypass_r;
    xres_nxt  = xres_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    prng_nxt  = prng_r;
    ovld_nxt  = ovld_r && !out_chan.ready;
    ox_nxt    = ox_r;
    oy_nxt    = oy_r;
    orng_nxt  = orng_r;
    q_ready   = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = '0;
    mul_a     = '0;
    mul_b     = '0;
    dreq      = '0;

    unique case (state_r)
      kbi_pkg::B_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          if (!q_item.is_query) begin
            ram_we = wr_ok;
          end else begin
            qt_nxt  = q_item.query_time;
            n_nxt   = n_c;
            idx_nxt = '0;
            if (n_c < CW'(2)) begin
              px_nxt    = '0;
              py_nxt    = '0;
              prng_nxt  = 1'b0;
              state_nxt = kbi_pkg::B_FIN;
            end else begin
              state_nxt = kbi_pkg::B_SRCH;
            end
          end
        end
      end

      // one key per cycle: compare the query against [previous, current)
      kbi_pkg::B_SRCH: begin
        if (idx_r == '0) begin
          tprev_nxt = ram_rd.key_time;
          idx_nxt   = AW'(1);
          ram_raddr = AW'(1);
        end else if (qt_r >= tprev_r && qt_r < ram_rd.key_time) begin
          t0_nxt    = tprev_r;
          t1_nxt    = ram_rd.key_time;
          w_nxt     = ram_rd.key_time - tprev_r;
          seg_nxt   = idx_r - AW'(1);
          ram_raddr = idx_r - AW'(1);
          state_nxt = kbi_pkg::B_RD_Y0;
        end else if (idx_inc >= n_r) begin
          px_nxt    = '0;
          py_nxt    = '0;
          prng_nxt  = 1'b0;
          state_nxt = kbi_pkg::B_FIN;
        end else begin
          tprev_nxt = ram_rd.key_time;
          idx_nxt   = idx_r + AW'(1);
          ram_raddr = idx_r + AW'(1);
        end
      end

      kbi_pkg::B_RD_Y0: begin
        y0_nxt    = ram_rd.key_level;
        ram_raddr = idx_r;
        state_nxt = kbi_pkg::B_RD_Y1;
      end

      kbi_pkg::B_RD_Y1: begin
        y1_nxt    = ram_rd.key_level;
        ein_nxt   = ram_rd.ease_in_pct;
        ram_raddr = prev_c;
        state_nxt = kbi_pkg::B_RD_PREV;
      end

      kbi_pkg::B_RD_PREV: begin
        eout_nxt  = ram_rd.ease_out_pct;
        mul_a     = {{(PW-32){1'b0}}, w_r};
        mul_b     = {{(kbi_pkg::S_BITS-14){1'b0}}, ein_r};
        mprod_nxt = mul_p;
        state_nxt = kbi_pkg::B_OFF2_MUL;
      end

      // (influence * width + half) / 25600: fold, then reciprocal multiply
      kbi_pkg::B_OFF2_MUL, kbi_pkg::B_OFF1_MUL: begin
        mul_a     = PW'(rcp_z);
        mul_b     = BW'(kbi_pkg::RCP_M);
        mprod_nxt = mul_p;
        fold_nxt  = kbi_pkg::QUO_W'(rcp_hi) * kbi_pkg::QUO_W'(kbi_pkg::FOLD_K);
        state_nxt = (state_r == kbi_pkg::B_OFF2_MUL) ? kbi_pkg::B_OFF2_SUM
                                                      : kbi_pkg::B_OFF1_SUM;
      end

      kbi_pkg::B_OFF2_SUM: begin
        off2_nxt  = off_sum;
        mul_a     = {{(PW-32){1'b0}}, w_r};
        mul_b     = {{(kbi_pkg::S_BITS-14){1'b0}}, eout_r};
        mprod_nxt = mul_p;
        state_nxt = kbi_pkg::B_OFF1_MUL;
      end

      kbi_pkg::B_OFF1_SUM: begin
        off1_nxt  = off_sum;
        state_nxt = kbi_pkg::B_S_GO;
      end

      kbi_pkg::B_S_GO: begin
        dreq.start    = 1'b1;
        dreq.rem_init = qt_r - t0_r;
        dreq.dvd_lo   = '0;
        dreq.pairs    = 5'(kbi_pkg::S_BITS / 2);
        dreq.divisor  = w_r;
        state_nxt     = kbi_pkg::B_S_WAIT;
      end

      kbi_pkg::B_S_WAIT: begin
        if (ddone) begin
          s_nxt      = dquo[kbi_pkg::S_BITS-1:0];
          pts_nxt[0] = {{(PW-32){1'b0}}, t0_r};
          pts_nxt[1] = {{(PW-32){1'b0}}, t0_r} + {{(PW-kbi_pkg::QUO_W){1'b0}}, off1_r};
          pts_nxt[2] = {{(PW-32){1'b0}}, t1_r} - {{(PW-kbi_pkg::QUO_W){1'b0}}, off2_r};
          pts_nxt[3] = {{(PW-32){1'b0}}, t1_r};
          step_nxt   = '0;
          ypass_nxt  = 1'b0;
          state_nxt  = kbi_pkg::B_BEZ;
        end
      end

      // de Casteljau on a shift line: lerp taps 0 and 1, result enters at 3
      kbi_pkg::B_BEZ: begin
        if (kbi_pkg::BEZ_COMPUTE[step_r]) begin
          mul_a     = pts_r[1] - pts_r[0];
          mul_b     = {1'b0, s_r};
          mprod_nxt = mul_p;
          state_nxt = kbi_pkg::B_LERP;
        end else begin
          pts_nxt[0] = pts_r[1];
          pts_nxt[1] = pts_r[2];
          pts_nxt[2] = pts_r[3];
          step_nxt   = step_r + 4'd1;
        end
      end

      kbi_pkg::B_LERP: begin
        if (step_r == 4'(kbi_pkg::BEZ_LAST)) begin
          if (!ypass_r) begin
            xres_nxt   = lerp_r;
            pts_nxt[0] = PW'(y0_r);
            pts_nxt[1] = PW'(y0_r);
            pts_nxt[2] = PW'(y1_r);
            pts_nxt[3] = PW'(y1_r);
            step_nxt   = '0;
            ypass_nxt  = 1'b1;
            state_nxt  = kbi_pkg::B_BEZ;
          end else begin
            if (xres_r < 0) begin
              px_nxt = '0;
            end else if (xres_r > $signed({{(PW-32){1'b0}}, 32'hFFFF_FFFF})) begin
              px_nxt = 32'hFFFF_FFFF;
            end else begin
              px_nxt = xres_r[31:0];
            end
            if (lerp_r < $signed({{(PW-32){1'b1}}, 32'h8000_0000})) begin
              py_nxt = 32'sh8000_0000;
            end else if (lerp_r > $signed({{(PW-32){1'b0}}, 32'h7FFF_FFFF})) begin
              py_nxt = 32'sh7FFF_FFFF;
            end else begin
              py_nxt = lerp_r[31:0];
            end
            prng_nxt  = 1'b1;
            state_nxt = kbi_pkg::B_FIN;
          end
        end else begin
          pts_nxt[0] = pts_r[1];
          pts_nxt[1] = pts_r[2];
          pts_nxt[2] = pts_r[3];
          pts_nxt[3] = lerp_r;
          step_nxt   = step_r + 4'd1;
          state_nxt  = kbi_pkg::B_BEZ;
        end
      end

      kbi_pkg::B_FIN: begin
        if (!ovld_r || out_chan.ready) begin
          ovld_nxt  = 1'b1;
          ox_nxt    = px_r;
          oy_nxt    = py_r;
          orng_nxt  = prng_r;
          state_nxt = kbi_pkg::B_IDLE;
        end
      end

      default: begin
        state_nxt = kbi_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kbi_pkg::B_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
    n_r     <= n_nxt;
    idx_r   <= idx_nxt;
    seg_r   <= seg_nxt;
    qt_r    <= qt_nxt;
    tprev_r <= tprev_nxt;
    t0_r    <= t0_nxt;
    t1_r    <= t1_nxt;
    w_r     <= w_nxt;
    y0_r    <= y0_nxt;
    y1_r    <= y1_nxt;
    ein_r   <= ein_nxt;
    eout_r  <= eout_nxt;
    off1_r  <= off1_nxt;
    off2_r  <= off2_nxt;
    fold_r  <= fold_nxt;
    s_r     <= s_nxt;
    mprod_r <= mprod_nxt;
    for (int k = 0; k < 4; k++) pts_r[k] <= pts_nxt[k];
    step_r  <= step_nxt;
    ypass_r <= ypass_nxt;
    xres_r  <= xres_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    prng_r  <= prng_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    orng_r  <= orng_nxt;
  end

  assign out_chan.valid    = ovld_r;
  assign out_chan.curve_x  = ox_r;
  assign out_chan.curve_y  = oy_r;
  assign out_chan.in_range = orng_r;

endmodule

`default_nettype wire

@@ rtl/keyframe_bezier_interpolator_unit.sv @@
// The unit keeps a table of up to MAX_KEYS animation keys and evaluates the
// cubic Bezier between two neighboring keys. A load request (mode 0) writes
// one key and returns nothing, and the back end stays ready for the next
// request. A query request (mode 1) returns one point: the segment search
// reads one key per cycle from the key RAM, then three more reads fetch the
// levels and influences, the two control offsets are scaled by an exact
// reciprocal of 25600 on the shared multiplier, the curve parameter goes
// through the radix-4 divider, and two de Casteljau passes share the
// multiplier. A query waits in the back end until the result register is
// free; the search, the divider and the single multiplier set its length.
// A two-entry request queue and the result register let the input and output
// sides stall independently. A query outside every segment returns zeros with
// in_range low. Reading a key slot never loaded gives undefined fields.
// ----------------------------------------------------------------------------
// keyframe_bezier_interpolator_unit - keyframe Bezier interpolator top level
// Config register, request front end and evaluation back end.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_bezier_interpolator_unit #(
  parameter int MAX_KEYS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  kbi_in_if.sink          in_chan,
  kbi_out_if.source       out_chan,
  input  wire logic       cfg_we,
  input  wire logic [4:0] cfg_wdata
);

  // keys_in_use register; the back end clamps it to MAX_KEYS per query
  logic [4:0] keys_in_use_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_in_use_r <= 5'd2;
    end else if (cfg_we) begin
      keys_in_use_r <= cfg_wdata;
    end
  end

  // queue between intake and evaluation
  logic            q_valid;
  logic            q_ready;
  kbi_pkg::qitem_t q_item;

  kbi_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready)
  );

  kbi_back #(.MAX_KEYS(MAX_KEYS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .keys_in_use (keys_in_use_r),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_ready     (q_ready),
    .out_chan    (out_chan)
  );

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - keyframe Bezier interpolator checker
// Loads key tables, queries the curve at random and directed times, and checks
// every returned point against a local fixed-point predictor of the block.
// ----------------------------------------------------------------------------

module testbench;

  localparam int NKEYS       = 16;
  localparam int DRAIN_WAIT  = 160;    // longer than one whole query
  localparam int STALL_LIMIT = 20000;  // cycles with no request or point moving
  localparam int RAND_ITEMS  = 800;
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic        [31:0] x;
    logic signed [31:0] y;
    logic               hit;
  } point_t;

  // Expected-point store plus a copy of the key table and the keys register.
  class curve_scoreboard;
    logic        [31:0] key_t[NKEYS];
    logic signed [31:0] key_y[NKEYS];
    logic        [14:0] ease_in[NKEYS];
    logic        [14:0] ease_out[NKEYS];
    logic        [4:0]  keys_reg = 5'd2;
    point_t             pending[$];
    int                 errors = 0;

    function longint lerp(longint a, longint b, longint s);
      longint p;
      p = (b - a) * s + (longint'(1) << (kbi_pkg::S_BITS - 1));
      return a + (p >>> kbi_pkg::S_BITS);   // arithmetic shift = floor
    endfunction

    function longint bez(longint p0, longint p1, longint p2, longint p3, longint s);
      longint a, b, c, d, e;
      a = lerp(p0, p1, s);
      b = lerp(p1, p2, s);
      c = lerp(p2, p3, s);
      d = lerp(a, b, s);
      e = lerp(b, c, s);
      return lerp(d, e, s);
    endfunction

    function point_t eval_curve(logic [31:0] q);
      point_t  pt;
      int      n, seg, prv;
      longint  t0, t1, w, off1, off2, s, x, y;
      pt  = '0;
      seg = -1;
      n   = (keys_reg > NKEYS) ? NKEYS : keys_reg;
      for (int i = 0; i + 1 < n; i++) begin
        if (seg < 0 && q >= key_t[i] && q < key_t[i+1]) seg = i;
      end
      if (seg < 0) return pt;
      prv  = (seg == 0) ? n - 1 : seg - 1;
      t0   = longint'(key_t[seg]);
      t1   = longint'(key_t[seg+1]);
      w    = t1 - t0;
      off1 = (longint'(ease_out[prv]) * w + kbi_pkg::PCT_HALF) / kbi_pkg::PCT_ONE;
      off2 = (longint'(ease_in[seg+1]) * w + kbi_pkg::PCT_HALF) / kbi_pkg::PCT_ONE;
      s    = ((longint'(q) - t0) << kbi_pkg::S_BITS) / w;
      x = bez(t0, t0 + off1, t1 - off2, t1, s);
      y = bez(longint'(key_y[seg]), longint'(key_y[seg]),
              longint'(key_y[seg+1]), longint'(key_y[seg+1]), s);
      if (x < 0) x = 0;
      if (x > 64'hFFFF_FFFF) x = 64'hFFFF_FFFF;
      if (y < -(longint'(1) << 31)) y = -(longint'(1) << 31);
      if (y > (longint'(1) << 31) - 1) y = (longint'(1) << 31) - 1;
      pt.x   = x[31:0];
      pt.y   = y[31:0];
      pt.hit = 1'b1;
      return pt;
    endfunction

    function void note_request(logic mode, logic [3:0] slot, logic [31:0] t,
                               logic signed [31:0] lv, logic [14:0] ein,
                               logic [14:0] eout, logic [31:0] q);
      if (mode == MODE_LOAD) begin
        key_t[slot]    = t;
        key_y[slot]    = lv;
        ease_in[slot]  = ein;
        ease_out[slot] = eout;
      end else begin
        pending.push_back(eval_curve(q));
      end
    endfunction

    function void check_point(logic [31:0] x, logic signed [31:0] y, logic hit);
      point_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected point x=%h y=%h hit=%b", x, y, hit);
        return;
      end
      want = pending.pop_front();
      if (want.x !== x || want.y !== y || want.hit !== hit) begin
        errors++;
        if (errors <= 10)
          $display("point mismatch: exp x=%h y=%h hit=%b, got x=%h y=%h hit=%b",
                   want.x, want.y, want.hit, x, y, hit);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [4:0] cfg_wdata;

  kbi_in_if  in_chan();
  kbi_out_if out_chan();

  keyframe_bezier_interpolator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  curve_scoreboard sb = new();

  int tx_idle_pct  = 0;   // chance of a gap before a request
  int rx_stall_pct = 0;   // chance of ready low on a cycle
  int hold_req     = 0;   // asks the receiver for a long hold-off
  int items_sent   = 0;
  int quiet_cycles = 0;
  logic [31:0] tbl_t[NKEYS];  // times last loaded, for query shaping

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_chan.valid && out_chan.ready)
        sb.check_point(out_chan.curve_x, out_chan.curve_y, out_chan.in_range);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Watchdog: nothing moving on either channel for too long is a hang.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_request(logic mode, logic [3:0] slot, logic [31:0] t,
                              logic signed [31:0] lv, logic [14:0] ein,
                              logic [14:0] eout, logic [31:0] q);
    int gap;
    gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.mode         <= mode;
    in_chan.key_slot     <= slot;
    in_chan.key_time     <= t;
    in_chan.key_level    <= lv;
    in_chan.ease_in_pct  <= ein;
    in_chan.ease_out_pct <= eout;
    in_chan.query_time   <= q;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sb.note_request(mode, slot, t, lv, ein, eout, q);
    items_sent++;
  endtask

  task automatic load_key(logic [3:0] slot, logic [31:0] t, logic signed [31:0] lv,
                          logic [14:0] ein, logic [14:0] eout);
    tbl_t[slot] = t;
    // query_time is don't-care on a load, so keep it noisy
    push_request(MODE_LOAD, slot, t, lv, ein, eout, $urandom);
  endtask

  task automatic query_at(logic [31:0] q);
    push_request(MODE_QUERY, 4'($urandom), $urandom, $urandom, 15'($urandom),
                 15'($urandom), q);
  endtask

  // Let the block go idle before touching the keys register.
  task automatic drain;
    in_chan.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_keys_reg(logic [4:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.keys_reg = v;
  endtask

  function automatic logic [14:0] rand_ease();
    if ($urandom_range(7) == 0) return 15'($urandom_range(0, 32767));  // may exceed 100%
    return 15'($urandom_range(0, kbi_pkg::PCT_ONE));
  endfunction

  // Sorted key times with random spacing; now and then one key is scrambled.
  task automatic load_table(int n);
    longint cur;
    int     tiny;
    tiny = ($urandom_range(3) == 0);
    cur  = $urandom_range(0, 32'h8000_0000);
    for (int i = 0; i < n; i++) begin
      load_key(4'(i), (cur > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : cur[31:0], $urandom,
               rand_ease(), rand_ease());
      cur += tiny ? $urandom_range(1, 16) : $urandom_range(1, 32'h1000_0000);
    end
    if ($urandom_range(9) == 0)
      load_key(4'($urandom_range(0, n - 1)), $urandom, $urandom, rand_ease(),
               rand_ease());
  endtask

  // Mostly inside the loaded span, some exactly on a key, some anywhere.
  task automatic random_query(int n);
    int     r;
    longint lo, span;
    r = $urandom_range(99);
    if (r < 10) begin
      query_at($urandom);
    end else if (r < 18) begin
      query_at(tbl_t[$urandom_range(0, n - 1)]);
    end else begin
      lo   = tbl_t[0];
      span = longint'(tbl_t[n-1]) - lo;
      if (span <= 0) query_at($urandom);
      else query_at(32'(lo + ({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF) % span));
    end
  endtask

  initial begin
    int          keys_list[8];
    int          n;
    logic [31:0] tq;
    keys_list = '{16, 2, 31, 8, 3, 12, 1, 0};
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    in_chan.valid        = 1'b0;
    in_chan.mode         = MODE_LOAD;
    in_chan.key_slot     = '0;
    in_chan.key_time     = '0;
    in_chan.key_level    = '0;
    in_chan.ease_in_pct  = '0;
    in_chan.ease_out_pct = '0;
    in_chan.query_time   = '0;
    tq                   = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: fill every slot so no search ever reads an empty entry.
    // Ends of the table carry the time and level extremes; influences span
    // zero, full 100% and the 15-bit maximum.
    write_keys_reg(5'd16);
    load_key(4'd0, 32'h0, 32'sh8000_0000, 15'd0, 15'd0);
    for (int i = 1; i < NKEYS - 1; i++)
      load_key(4'(i), 32'(i) * 32'h1000_0000, $urandom,
               (i % 3 == 0) ? 15'h7FFF : 15'(kbi_pkg::PCT_ONE),
               (i % 2) ? 15'd0 : 15'h7FFF);
    load_key(4'(NKEYS - 1), 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 15'(kbi_pkg::PCT_ONE),
             15'h7FFF);
    query_at(32'h0);            // first key exactly
    query_at(32'h0000_0001);
    query_at(32'h7FFF_FFFF);
    query_at(32'hFFFF_FFFE);    // last segment, near its end
    query_at(32'hFFFF_FFFF);    // at the last key: no segment holds it
    write_keys_reg(5'd0);       // too few keys: nothing found
    query_at(32'h1234_5678);
    write_keys_reg(5'd1);
    query_at(tq);
    write_keys_reg(5'd31);      // saturates to the table size
    query_at(32'hF000_0001);

    // Random phases, each with its own key count and idle pattern.
    for (int p = 0; items_sent < RAND_ITEMS + 25; p++) begin
      n = keys_list[p % 8];
      write_keys_reg(5'(n));
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 56; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 56; end
        default: begin tx_idle_pct = 18; rx_stall_pct = 18; end
      endcase
      if (p == 4) hold_req = 600;  // receiver off while the sender keeps pushing
      if (n > NKEYS) n = NKEYS;
      if (n < 2) n = 2;
      for (int k = 0; k < 100; k++) begin
        if (k % 25 == 0) load_table(n);
        if ($urandom_range(19) == 0)
          load_key(4'($urandom_range(0, NKEYS - 1)), $urandom, $urandom,
                   rand_ease(), rand_ease());
        else
          random_query(n);
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/kbi_pkg.sv
rtl/kbi_in_if.sv
rtl/kbi_out_if.sv
rtl/kbi_ram.sv
rtl/kbi_div.sv
rtl/kbi_front.sv
rtl/kbi_back.sv
rtl/keyframe_bezier_interpolator_unit.sv
dv/testbench.sv
